[rtl/mns_pkg.sv]
// ----------------------------------------------------------------------------
// mns_pkg
// Shared types and constants of the melody note sequencer.
// ----------------------------------------------------------------------------
package mns_pkg;

    // item operation codes
    typedef logic [2:0] t_op;
    localparam t_op OP_TICK    = 3'd0;
    localparam t_op OP_START   = 3'd1;
    localparam t_op OP_STOP    = 3'd2;
    localparam t_op OP_LOAD    = 3'd3;
    localparam t_op OP_RESTART = 3'd4;

    // result event codes
    typedef logic [1:0] t_event;
    localparam t_event EV_NONE   = 2'd0;
    localparam t_event EV_NOTE   = 2'd1;
    localparam t_event EV_FINISH = 2'd2;

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BASE_DURATION = 1'b0;
    localparam t_cfg_idx CFG_NOTE_COUNT    = 1'b1;

    localparam int FREQ_W    = 16;
    localparam int LEN_W     = 16;
    localparam int DIV_W     = 8;
    localparam int NOTE_W    = 7;
    localparam int ELAPSED_W = 17;
    localparam int ENTRY_W   = FREQ_W + DIV_W;
    localparam int INDEX_W   = 6;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [LEN_W-1:0]     BASE_DUR_INIT = 16'd1000;

endpackage

[rtl/mns_ram.sv]
// ----------------------------------------------------------------------------
// mns_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mns_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/mns_div.sv]
// ----------------------------------------------------------------------------
// mns_div
// Restoring divider, 16-bit dividend by nonzero 8-bit divisor, one quotient
// bit per cycle. o_done pulses for one cycle when o_quotient is final.
// ----------------------------------------------------------------------------
module mns_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mns_pkg::LEN_W-1:0]  i_dividend,
    input  logic [mns_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [mns_pkg::LEN_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(mns_pkg::LEN_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [mns_pkg::LEN_W-1:0]   r_quo;
    logic [mns_pkg::DIV_W-1:0]   r_rem;
    logic [mns_pkg::DIV_W-1:0]   r_dvs;

    logic [mns_pkg::DIV_W:0]     shifted;
    logic                        fits;
    logic [mns_pkg::DIV_W:0]     diff;

    assign shifted = {r_rem, r_quo[mns_pkg::LEN_W-1]};
    assign fits    = (shifted >= {1'b0, r_dvs});
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(mns_pkg::LEN_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[mns_pkg::LEN_W-2:0], fits};
            r_rem <= fits ? diff[mns_pkg::DIV_W-1:0] : shifted[mns_pkg::DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/melody_note_sequencer.sv]
// ----------------------------------------------------------------------------
// melody_note_sequencer
// Plays a melody from a note table, one item per tick or control command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one item per transfer: a tick,
//   start, stop, note load or restart request. Every item gives exactly one
//   result on the output channel (o_valid / i_stall) with the state after it.
//   The note table sits in a RAM with registered read. Items that do not
//   load a note go straight to the push state; no new item is taken until
//   the last result is pushed. Items that load a note (start, restart tick,
//   note advance) read the table, then run the note length through a
//   bit-serial divider, one quotient bit a cycle, before the result is pushed.
//   The input is taken while an earlier result still waits in the output
//   register; a stalled receiver holds the result, and the block stalls the
//   sender while it works on an item, also while its result waits to go out.
//   Configuration writes land at once; issue them only while idle.
//   Reset (synchronous, active low) stops playback and clears the counters;
//   table contents are undefined until loaded. No clearing pass is needed.
// ----------------------------------------------------------------------------
module melody_note_sequencer #(
    parameter int MAX_NOTES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  mns_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [mns_pkg::LEN_W-1:0]           i_cfg_data,
    // input items
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_op,
    input  logic [mns_pkg::INDEX_W-1:0]         i_entry_index,
    input  logic [mns_pkg::FREQ_W-1:0]          i_entry_freq,
    input  logic [mns_pkg::DIV_W-1:0]           i_entry_divisor,
    // results
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_tone_active,
    output logic [mns_pkg::FREQ_W-1:0]          o_tone_freq,
    output logic [mns_pkg::LEN_W-1:0]           o_note_length,
    output logic [mns_pkg::NOTE_W-1:0]          o_position,
    output logic                                o_playing,
    output logic [1:0]                          o_event_res
);

    localparam int AW     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int NW_MIN = $clog2(MAX_NOTES + 1);
    localparam int NW     = (NW_MIN > mns_pkg::NOTE_W) ? NW_MIN : mns_pkg::NOTE_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_NOTES);
    localparam int CMP_W  = mns_pkg::ELAPSED_W + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    // configuration registers
    logic [mns_pkg::LEN_W-1:0]     r_base_dur;
    logic [mns_pkg::NOTE_W-1:0]    r_note_cnt;

    // playback state
    logic [1:0]                    r_state,   n_state;
    logic [mns_pkg::NOTE_W-1:0]    r_note,    n_note;
    logic [mns_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [mns_pkg::LEN_W-1:0]     r_length,  n_length;
    logic [mns_pkg::FREQ_W-1:0]    r_freq,    n_freq;
    logic                          r_play,    n_play;
    logic                          r_pend,    n_pend;
    mns_pkg::t_event               r_event,   n_event;

    // output register
    logic                          r_out_valid;
    logic                          r_out_active;
    logic [mns_pkg::FREQ_W-1:0]    r_out_freq;
    logic [mns_pkg::LEN_W-1:0]     r_out_len;
    logic [mns_pkg::NOTE_W-1:0]    r_out_pos;
    logic                          r_out_play;
    mns_pkg::t_event               r_out_event;

    logic                          in_xfer;
    logic                          out_free;
    logic                          push;
    logic [NW-1:0]                 notes_used;
    logic [NW-1:0]                 next_note;
    logic [NW-1:0]                 load_idx;
    logic [mns_pkg::ELAPSED_W-1:0] elapsed_inc;
    logic                          advance;

    logic                          ram_we;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [mns_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [mns_pkg::DIV_W-1:0]     rd_div;
    logic                          div_start;
    logic                          div_done;
    logic [mns_pkg::LEN_W-1:0]     div_quo;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign push     = (r_state == S_PUSH) && out_free;
    assign o_stall  = (r_state != S_IDLE);

    assign notes_used = (NW'(r_note_cnt) > MAX_N) ? MAX_N : NW'(r_note_cnt);
    assign next_note  = NW'(r_note) + 1'b1;
    assign load_idx   = NW'(i_entry_index);

    assign elapsed_inc = (r_elapsed < mns_pkg::ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    // 1.25x the note length, kept exact as elapsed*4 >= length*5
    assign advance = ({elapsed_inc, 2'b00} >=
                      ({1'b0, r_length, 2'b00} + CMP_W'(r_length)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_dur <= mns_pkg::BASE_DUR_INIT;
            r_note_cnt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mns_pkg::CFG_BASE_DURATION: r_base_dur <= i_cfg_data;
                mns_pkg::CFG_NOTE_COUNT:    r_note_cnt <= i_cfg_data[mns_pkg::NOTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_note    = r_note;
        n_elapsed = r_elapsed;
        n_length  = r_length;
        n_freq    = r_freq;
        n_play    = r_play;
        n_pend    = r_pend;
        n_event   = r_event;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_event = mns_pkg::EV_NONE;
                    n_state = S_PUSH;
                    if (i_op == mns_pkg::OP_START ||
                        (i_op == mns_pkg::OP_TICK && r_play && r_pend)) begin
                        // begin melody at note 0
                        if (i_op == mns_pkg::OP_TICK) begin
                            n_pend = 1'b0;
                        end
                        n_note    = '0;
                        n_elapsed = '0;
                        n_play    = (notes_used != '0);
                        n_event   = (notes_used != '0) ? mns_pkg::EV_NOTE
                                                       : mns_pkg::EV_FINISH;
                        ram_re    = 1'b1;
                        n_state   = S_READ;
                    end else if (i_op == mns_pkg::OP_TICK && r_play) begin
                        n_elapsed = elapsed_inc;
                        if (advance) begin
                            n_note = next_note[mns_pkg::NOTE_W-1:0];
                            if (next_note < notes_used) begin
                                n_elapsed = '0;
                                n_event   = mns_pkg::EV_NOTE;
                                ram_re    = 1'b1;
                                ram_raddr = next_note[AW-1:0];
                                n_state   = S_READ;
                            end else begin
                                n_play  = 1'b0;
                                n_event = mns_pkg::EV_FINISH;
                            end
                        end
                    end else if (i_op == mns_pkg::OP_STOP) begin
                        n_play = 1'b0;
                    end else if (i_op == mns_pkg::OP_LOAD) begin
                        ram_we = (load_idx < MAX_N);
                    end else if (i_op == mns_pkg::OP_RESTART) begin
                        n_pend = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_freq    = ram_rdata[mns_pkg::FREQ_W-1:0];
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_length = div_quo;
                    n_state  = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_note    <= '0;
            r_elapsed <= '0;
            r_length  <= '0;
            r_freq    <= '0;
            r_play    <= 1'b0;
            r_pend    <= 1'b0;
            r_event   <= mns_pkg::EV_NONE;
        end else begin
            r_state   <= n_state;
            r_note    <= n_note;
            r_elapsed <= n_elapsed;
            r_length  <= n_length;
            r_freq    <= n_freq;
            r_play    <= n_play;
            r_pend    <= n_pend;
            r_event   <= n_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_active <= r_play && ({1'b0, r_length} > r_elapsed);
            r_out_freq   <= r_freq;
            r_out_len    <= r_length;
            r_out_pos    <= r_note;
            r_out_play   <= r_play;
            r_out_event  <= r_event;
        end
    end

    assign rd_div = (ram_rdata[mns_pkg::ENTRY_W-1:mns_pkg::FREQ_W] == '0)
                    ? mns_pkg::DIV_W'(1)
                    : ram_rdata[mns_pkg::ENTRY_W-1:mns_pkg::FREQ_W];

    mns_ram #(
        .WIDTH (mns_pkg::ENTRY_W),
        .DEPTH (MAX_NOTES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (load_idx[AW-1:0]),
        .i_wr_data ({i_entry_divisor, i_entry_freq}),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    mns_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_base_dur),
        .i_divisor  (rd_div),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_valid       = r_out_valid;
    assign o_tone_active = r_out_active;
    assign o_tone_freq   = r_out_freq;
    assign o_note_length = r_out_len;
    assign o_position    = r_out_pos;
    assign o_playing     = r_out_play;
    assign o_event_res   = r_out_event;

    // table is never written and read in the same cycle
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("table read and write collide");

    // a divider result only arrives while waiting for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside of divide state");

    // a new note is reported only while playing, a finish only when stopped
    a_event_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_event_res != mns_pkg::EV_NOTE || o_playing) &&
                     (o_event_res != mns_pkg::EV_FINISH || !o_playing)))
        else $error("event code disagrees with playing flag");

    // the table read issued in idle is consumed by the read state next cycle
    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_state == S_READ))
        else $error("table read not followed by read state");

endmodule
